/* rtl/tsc_pkg.sv */
// Shared constants, codes and payload types of the tagged stack with context banks.
package tsc_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int CONTEXT_COUNT = 8;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CTX_W = (CONTEXT_COUNT > 1) ? $clog2(CONTEXT_COUNT) : 1;
   localparam int BANK_AW = CTX_W + ADDR_W;
   localparam int BANK_ROWS = 2 ** BANK_AW;
   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int TYPE_W = 3;
   localparam int VALUE_W = 64;

   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP = 2'd1;
   localparam logic [1:0] MODE_SAVE = 2'd2;
   localparam logic [1:0] MODE_RESTORE = 2'd3;

   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_OVERFLOW = 2'd1;
   localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [TYPE_W-1:0] item_type;
      logic signed [VALUE_W-1:0] item_value;
      logic [3:0] bank_id;
   } req_type;

   typedef struct packed {
      logic [TYPE_W-1:0] out_type;
      logic signed [VALUE_W-1:0] out_value;
      logic [DEPTH_W-1:0] depth_now;
      logic [1:0] fault;
      logic still_running;
   } rsp_type;

   typedef struct packed {
      logic [TYPE_W-1:0] tag;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic [CTX_W-1:0] rd_ctx;
      logic [ADDR_W-1:0] rd_idx;
      logic wr_en;
      logic [CTX_W-1:0] wr_ctx;
      logic [ADDR_W-1:0] wr_idx;
      logic save_en;
      logic [CTX_W-1:0] save_ctx;
      logic [DEPTH_W-1:0] save_depth;
      logic [CTX_W-1:0] look_ctx;
   } bank_ctrl_type;

endpackage

/* rtl/tsc_bank_store.sv */
// Context bank storage: entry memory, saved depths and per-bank written flags.
module tsc_bank_store (
   input  logic                        clock,
   input  logic                        reset,
   input  tsc_pkg::bank_ctrl_type      ctrl,
   input  tsc_pkg::entry_type          wr_data,
   output tsc_pkg::entry_type          rd_data,
   output logic [tsc_pkg::DEPTH_W-1:0] look_depth
);
   import tsc_pkg::*;

   entry_type bank_mem [BANK_ROWS];
   entry_type rd_q_ff;
   logic rd_valid_ff;
   logic [CONTEXT_COUNT-1:0] saved_ff;
   logic [DEPTH_W-1:0] depth_ff [CONTEXT_COUNT];

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         bank_mem[{ctrl.wr_ctx, ctrl.wr_idx}] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_q_ff <= bank_mem[{ctrl.rd_ctx, ctrl.rd_idx}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         saved_ff <= '0;
         rd_valid_ff <= 1'b0;
         for (int i = 0; i < CONTEXT_COUNT; i++) begin
            depth_ff[i] <= DEPTH_W'(1);
         end
      end else begin
         if (ctrl.save_en) begin
            saved_ff[ctrl.save_ctx] <= 1'b1;
            depth_ff[ctrl.save_ctx] <= ctrl.save_depth;
         end
         if (ctrl.rd_en) begin
            rd_valid_ff <= saved_ff[ctrl.rd_ctx];
         end
      end
   end

   // A bank that was never saved reads as zeroed entries.
   assign rd_data = rd_valid_ff ? rd_q_ff : '0;
   assign look_depth = depth_ff[ctrl.look_ctx];

endmodule

/* rtl/tagged_stack_with_context_banks.sv */
// Top level of the tagged operand stack with context save and restore.
// Push and pop leave busy low: a new transfer may follow in the next cycle, and the
// result strobe rises in the cycle after the transfer. Save and restore copy the live
// entries one per cycle between the stack memory and the bank memory while busy is high,
// and the result strobe rises in the same cycle that busy falls. A context id at or
// beyond the bank count is answered in the cycle after the transfer, as a push is, and
// changes nothing. Results cannot be held off.
module tagged_stack_with_context_banks (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tsc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tsc_pkg::rsp_type rsp_data
);
   import tsc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SAVE = 2'd1;
   localparam logic [1:0] ST_RESTORE = 2'd2;

   entry_type stack_mem [STACK_DEPTH];
   entry_type stack_rd_ff;
   entry_type stack_wdata;
   entry_type bank_rd;
   logic stack_we;
   logic stack_re;
   logic [ADDR_W-1:0] stack_waddr;
   logic [ADDR_W-1:0] stack_raddr;

   logic [1:0] state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic run_ff, run_in;
   logic [DEPTH_W-1:0] idx_ff, idx_in;
   logic [DEPTH_W-1:0] n_ff, n_in;
   logic [CTX_W-1:0] ctx_ff, ctx_in;
   logic wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0] wb_idx_ff, wb_idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_pop_ff, rsp_pop_in;
   logic [1:0] rsp_fault_ff, rsp_fault_in;

   bank_ctrl_type bank_ctrl;
   logic [DEPTH_W-1:0] look_depth;
   logic accept;
   logic ctx_ok;
   logic [CTX_W-1:0] ctx_sel;
   logic full;
   logic empty;

   tsc_bank_store u_bank (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (bank_ctrl),
      .wr_data    (stack_rd_ff),
      .rd_data    (bank_rd),
      .look_depth (look_depth)
   );

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign ctx_ok = (32'(req_data.bank_id) < CONTEXT_COUNT);
   assign ctx_sel = req_data.bank_id[CTX_W-1:0];
   assign full = (depth_ff == DEPTH_W'(STACK_DEPTH));
   assign empty = (depth_ff == '0);

   always_comb begin
      state_in = state_ff;
      depth_in = depth_ff;
      run_in = run_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      ctx_in = ctx_ff;
      wb_valid_in = 1'b0;
      wb_idx_in = idx_ff[ADDR_W-1:0];
      rsp_valid_in = 1'b0;
      rsp_pop_in = 1'b0;
      rsp_fault_in = FAULT_NONE;
      stack_we = 1'b0;
      stack_waddr = depth_ff[ADDR_W-1:0];
      stack_wdata = '{tag: req_data.item_type, value: req_data.item_value};
      stack_re = 1'b0;
      stack_raddr = ADDR_W'(depth_ff - DEPTH_W'(1));
      bank_ctrl = '0;
      bank_ctrl.look_ctx = ctx_sel;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  MODE_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (!full) begin
                        stack_we = 1'b1;
                        depth_in = depth_ff + DEPTH_W'(1);
                     end else begin
                        rsp_fault_in = FAULT_OVERFLOW;
                        run_in = 1'b0;
                     end
                  end
                  MODE_POP: begin
                     rsp_valid_in = 1'b1;
                     if (!empty) begin
                        stack_re = 1'b1;
                        depth_in = depth_ff - DEPTH_W'(1);
                        rsp_pop_in = 1'b1;
                     end else begin
                        rsp_fault_in = FAULT_UNDERFLOW;
                        run_in = 1'b0;
                     end
                  end
                  MODE_SAVE: begin
                     if (ctx_ok) begin
                        bank_ctrl.save_en = 1'b1;
                        bank_ctrl.save_ctx = ctx_sel;
                        bank_ctrl.save_depth = depth_ff;
                        n_in = depth_ff;
                        idx_in = '0;
                        ctx_in = ctx_sel;
                        state_in = ST_SAVE;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  MODE_RESTORE: begin
                     if (ctx_ok) begin
                        n_in = look_depth;
                        depth_in = look_depth;
                        idx_in = '0;
                        ctx_in = ctx_sel;
                        state_in = ST_RESTORE;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SAVE: begin
            bank_ctrl.wr_en = wb_valid_ff;
            bank_ctrl.wr_ctx = ctx_ff;
            bank_ctrl.wr_idx = wb_idx_ff;
            if (idx_ff != n_ff) begin
               stack_re = 1'b1;
               stack_raddr = idx_ff[ADDR_W-1:0];
               idx_in = idx_ff + DEPTH_W'(1);
               wb_valid_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         ST_RESTORE: begin
            stack_we = wb_valid_ff;
            stack_waddr = wb_idx_ff;
            stack_wdata = bank_rd;
            if (idx_ff != n_ff) begin
               bank_ctrl.rd_en = 1'b1;
               bank_ctrl.rd_ctx = ctx_ff;
               bank_ctrl.rd_idx = idx_ff[ADDR_W-1:0];
               idx_in = idx_ff + DEPTH_W'(1);
               wb_valid_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         depth_ff <= '0;
         run_ff <= 1'b1;
         wb_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_pop_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         run_ff <= run_in;
         wb_valid_ff <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_pop_ff <= rsp_pop_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      n_ff <= n_in;
      ctx_ff <= ctx_in;
      wb_idx_ff <= wb_idx_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   // The depth and run flag are final in the cycle that the result is shown.
   always_comb begin
      rsp_data.out_type = rsp_pop_ff ? stack_rd_ff.tag : '0;
      rsp_data.out_value = rsp_pop_ff ? stack_rd_ff.value : '0;
      rsp_data.depth_now = depth_ff;
      rsp_data.fault = rsp_fault_ff;
      rsp_data.still_running = run_ff;
   end

   assign rsp_strobe = rsp_valid_ff;

   a_no_result_while_copying: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("Result strobe raised during a context copy.");

   a_fault_clears_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_fault_ff != FAULT_NONE) |-> !run_ff)
      else $error("Faulting result reports a set run flag.");

   a_run_sticky: assert property (@(posedge clock) disable iff (reset)
      !run_ff |=> !run_ff)
      else $error("Run flag was set again without reset.");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("Stack depth beyond capacity.");

   a_writeback_in_copy: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> busy)
      else $error("Copy write-back pending outside a context copy.");

   a_copy_index_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> idx_ff <= n_ff)
      else $error("Copy index ran past the copy length.");

endmodule
